/* rtl/spi_pkg.sv */
// Shared widths, types and helper functions of the segment pair intersection block.
`default_nettype none
package spi_pkg;

	localparam int CW = 32;       // coordinate width
	localparam int DW = CW + 1;   // difference of two coordinates
	localparam int PW = 2 * DW;   // product of two differences
	localparam int XW = PW + 1;   // cross product, signed
	localparam int MW = PW;       // magnitude of a cross product
	localparam int QW = DW;       // quotient bits
	localparam int NW = MW + QW;  // dividend width
	localparam int SW = CW + 3;   // point sum before saturation
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	// One classified segment pair, as it waits between the two halves.
	typedef struct packed {
		logic                 hit;
		logic                 par;
		logic signed [CW-1:0] a1r;
		logic signed [CW-1:0] a1z;
		logic [DW-1:0]        mdr;
		logic [DW-1:0]        mdz;
		logic                 negr;
		logic                 negz;
		logic [MW-1:0]        mtn;
		logic [MW-1:0]        mden;
	} item_t;

	// What travels beside the division unchanged.
	typedef struct packed {
		logic                 hit;
		logic                 par;
		logic signed [CW-1:0] a1r;
		logic signed [CW-1:0] a1z;
		logic                 negr;
		logic                 negz;
	} side_t;

	// True when x/den lies in [0,1], both ends included.
	function automatic logic in_unit(input logic signed [XW-1:0] x,
		input logic signed [XW-1:0] den);
		logic res;
		if (den < 0) begin
			res = (den <= x) && (x <= 0);
		end else begin
			res = (x >= 0) && (x <= den);
		end
		return res;
	endfunction

	function automatic logic [MW-1:0] mag_x(input logic signed [XW-1:0] x);
		logic signed [XW-1:0] m;
		m = (x < 0) ? -x : x;
		return m[MW-1:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/spi_front.sv */
// Front half: differences, cross products and hit classification.
`default_nettype none
module spi_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire logic                          in_valid,
	input  wire logic signed [spi_pkg::CW-1:0] first_start_r,
	input  wire logic signed [spi_pkg::CW-1:0] first_start_z,
	input  wire logic signed [spi_pkg::CW-1:0] first_end_r,
	input  wire logic signed [spi_pkg::CW-1:0] first_end_z,
	input  wire logic signed [spi_pkg::CW-1:0] second_start_r,
	input  wire logic signed [spi_pkg::CW-1:0] second_start_z,
	input  wire logic signed [spi_pkg::CW-1:0] second_end_r,
	input  wire logic signed [spi_pkg::CW-1:0] second_end_z,
	output logic                               push,
	output spi_pkg::item_t                     push_item
);
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [spi_pkg::CW-1:0] a1r_s1, a1z_s1, a1r_s2, a1z_s2, a1r_s3, a1z_s3;
	logic signed [spi_pkg::DW-1:0] dar_s1, daz_s1, dbr_s1, dbz_s1, der_s1, dez_s1;
	logic signed [spi_pkg::DW-1:0] dar_s2, daz_s2, dar_s3, daz_s3;
	logic signed [spi_pkg::PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic signed [spi_pkg::XW-1:0] den_s3, tn_s3, un_s3;
	spi_pkg::item_t item_s4, nxt;

	function automatic logic signed [spi_pkg::DW-1:0] diff(
		input logic signed [spi_pkg::CW-1:0] a, input logic signed [spi_pkg::CW-1:0] b);
		return spi_pkg::DW'(a) - spi_pkg::DW'(b);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		nxt.par  = (den_s3 == '0);
		nxt.hit  = !nxt.par && spi_pkg::in_unit(tn_s3, den_s3)
			&& spi_pkg::in_unit(un_s3, den_s3);
		nxt.a1r  = a1r_s3;
		nxt.a1z  = a1z_s3;
		nxt.mdr  = (dar_s3 < 0) ? spi_pkg::DW'(-dar_s3) : spi_pkg::DW'(dar_s3);
		nxt.mdz  = (daz_s3 < 0) ? spi_pkg::DW'(-daz_s3) : spi_pkg::DW'(daz_s3);
		nxt.negr = dar_s3[spi_pkg::DW-1] ^ tn_s3[spi_pkg::XW-1] ^ den_s3[spi_pkg::XW-1];
		nxt.negz = daz_s3[spi_pkg::DW-1] ^ tn_s3[spi_pkg::XW-1] ^ den_s3[spi_pkg::XW-1];
		nxt.mtn  = spi_pkg::mag_x(tn_s3);
		nxt.mden = spi_pkg::mag_x(den_s3);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a1r_s1 <= first_start_r;
			a1z_s1 <= first_start_z;
			dar_s1 <= diff(first_end_r, first_start_r);
			daz_s1 <= diff(first_end_z, first_start_z);
			dbr_s1 <= diff(second_end_r, second_start_r);
			dbz_s1 <= diff(second_end_z, second_start_z);
			der_s1 <= diff(second_start_r, first_start_r);
			dez_s1 <= diff(second_start_z, first_start_z);

			a1r_s2 <= a1r_s1;
			a1z_s2 <= a1z_s1;
			dar_s2 <= dar_s1;
			daz_s2 <= daz_s1;
			p0_s2  <= spi_pkg::PW'(dar_s1) * spi_pkg::PW'(dbz_s1);
			p1_s2  <= spi_pkg::PW'(daz_s1) * spi_pkg::PW'(dbr_s1);
			p2_s2  <= spi_pkg::PW'(der_s1) * spi_pkg::PW'(dbz_s1);
			p3_s2  <= spi_pkg::PW'(dez_s1) * spi_pkg::PW'(dbr_s1);
			p4_s2  <= spi_pkg::PW'(der_s1) * spi_pkg::PW'(daz_s1);
			p5_s2  <= spi_pkg::PW'(dez_s1) * spi_pkg::PW'(dar_s1);

			a1r_s3 <= a1r_s2;
			a1z_s3 <= a1z_s2;
			dar_s3 <= dar_s2;
			daz_s3 <= daz_s2;
			den_s3 <= spi_pkg::XW'(p0_s2) - spi_pkg::XW'(p1_s2);
			tn_s3  <= spi_pkg::XW'(p2_s2) - spi_pkg::XW'(p3_s2);
			un_s3  <= spi_pkg::XW'(p4_s2) - spi_pkg::XW'(p5_s2);

			item_s4 <= nxt;
		end
	end

	assign push      = adv && v_s4;
	assign push_item = item_s4;

endmodule
`default_nettype wire

/* rtl/spi_queue.sv */
// Short queue of classified words between the front and back halves.
`default_nettype none
module spi_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire spi_pkg::item_t push_item,
	input  wire logic           pop,
	output spi_pkg::item_t      head,
	output logic                not_empty,
	output logic                full
);
	spi_pkg::item_t mem_q [0:spi_pkg::QDEPTH-1];
	logic [spi_pkg::QAW-1:0] wr_q, rd_q;
	logic [spi_pkg::QAW:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign head      = mem_q[rd_q];
	assign not_empty = (cnt_q != '0);
	assign full      = (cnt_q == (spi_pkg::QAW + 1)'(spi_pkg::QDEPTH));

endmodule
`default_nettype wire

/* rtl/spi_back.sv */
// Back half: scaled numerator, pipelined restoring division and point output.
`default_nettype none
module spi_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          not_empty,
	input  wire spi_pkg::item_t                head,
	output logic                               pop,
	input  wire logic                          out_stall,
	output logic                               out_valid,
	output logic                               hit,
	output logic                               parallel,
	output logic signed [spi_pkg::CW-1:0]      point_r,
	output logic signed [spi_pkg::CW-1:0]      point_z
);
	localparam int QW = spi_pkg::QW;

	logic adv;
	logic v_s5;
	spi_pkg::side_t side_s5;
	logic [spi_pkg::MW-1:0] den_s5;
	logic [spi_pkg::PW-1:0] plo_r_s5, phi_r_s5, plo_z_s5, phi_z_s5;
	logic [spi_pkg::NW-1:0] num_r, num_z;

	// Index 0 is the dividend stage; index k holds k quotient bits.
	logic                   vld_s  [0:QW];
	spi_pkg::side_t         side_s [0:QW];
	logic [spi_pkg::MW-1:0] den_s  [0:QW];
	logic [spi_pkg::MW-1:0] rem_r_s [0:QW];
	logic [spi_pkg::MW-1:0] rem_z_s [0:QW];
	logic [QW-1:0]          low_r_s [0:QW];
	logic [QW-1:0]          low_z_s [0:QW];

	logic out_valid_q, hit_q, par_q;
	logic signed [spi_pkg::CW-1:0] pr_q, pz_q, pr_n, pz_n;

	function automatic logic signed [spi_pkg::CW-1:0] place(
		input logic signed [spi_pkg::CW-1:0] a1, input logic [QW-1:0] q, input logic neg);
		logic signed [spi_pkg::SW-1:0] qe, s;
		logic signed [spi_pkg::SW-1:0] hi, lo;
		logic signed [spi_pkg::CW-1:0] res;
		qe = spi_pkg::SW'($signed({1'b0, q}));
		s  = spi_pkg::SW'(a1) + (neg ? -qe : qe);
		hi = spi_pkg::SW'({1'b0, {(spi_pkg::CW-1){1'b1}}});
		lo = -hi - 1;
		if (s > hi) begin
			res = hi[spi_pkg::CW-1:0];
		end else if (s < lo) begin
			res = lo[spi_pkg::CW-1:0];
		end else begin
			res = s[spi_pkg::CW-1:0];
		end
		return res;
	endfunction

	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && not_empty;

	always_comb begin
		num_r = spi_pkg::NW'(plo_r_s5) + {phi_r_s5, {QW{1'b0}}};
		num_z = spi_pkg::NW'(plo_z_s5) + {phi_z_s5, {QW{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			v_s5 <= pop;
			vld_s[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5.hit  <= head.hit;
			side_s5.par  <= head.par;
			side_s5.a1r  <= head.a1r;
			side_s5.a1z  <= head.a1z;
			side_s5.negr <= head.negr;
			side_s5.negz <= head.negz;
			den_s5       <= head.mden;
			plo_r_s5 <= spi_pkg::PW'(head.mdr) * spi_pkg::PW'(head.mtn[QW-1:0]);
			phi_r_s5 <= spi_pkg::PW'(head.mdr) * spi_pkg::PW'(head.mtn[spi_pkg::MW-1:QW]);
			plo_z_s5 <= spi_pkg::PW'(head.mdz) * spi_pkg::PW'(head.mtn[QW-1:0]);
			phi_z_s5 <= spi_pkg::PW'(head.mdz) * spi_pkg::PW'(head.mtn[spi_pkg::MW-1:QW]);

			side_s[0]  <= side_s5;
			den_s[0]   <= den_s5;
			rem_r_s[0] <= num_r[spi_pkg::NW-1:QW];
			rem_z_s[0] <= num_z[spi_pkg::NW-1:QW];
			low_r_s[0] <= num_r[QW-1:0];
			low_z_s[0] <= num_z[QW-1:0];
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [spi_pkg::XW-1:0] tr, tz, dx;
		logic gr, gz;

		always_comb begin
			dx = {1'b0, den_s[j]};
			tr = {rem_r_s[j], low_r_s[j][QW-1]};
			tz = {rem_z_s[j], low_z_s[j][QW-1]};
			gr = (tr >= dx);
			gz = (tz >= dx);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (adv) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		// The quotient bit shifts in where the consumed dividend bit left.
		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[j+1]  <= side_s[j];
				den_s[j+1]   <= den_s[j];
				rem_r_s[j+1] <= gr ? spi_pkg::MW'(tr - dx) : tr[spi_pkg::MW-1:0];
				rem_z_s[j+1] <= gz ? spi_pkg::MW'(tz - dx) : tz[spi_pkg::MW-1:0];
				low_r_s[j+1] <= {low_r_s[j][QW-2:0], gr};
				low_z_s[j+1] <= {low_z_s[j][QW-2:0], gz};
			end
		end
	end

	always_comb begin
		pr_n = place(side_s[QW].a1r, low_r_s[QW], side_s[QW].negr);
		pz_n = place(side_s[QW].a1z, low_z_s[QW], side_s[QW].negz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q <= side_s[QW].hit;
			par_q <= side_s[QW].par;
			pr_q  <= side_s[QW].hit ? pr_n : '0;
			pz_q  <= side_s[QW].hit ? pz_n : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign parallel  = par_q;
	assign point_r   = pr_q;
	assign point_z   = pz_q;

endmodule
`default_nettype wire

/* rtl/segment_pair_intersection.sv */
// Top level of the 2D segment pair intersection block.
//
//   channel   handshake             word
//   input     in_valid / in_stall   eight Q16.16 endpoint coordinates
//   output    out_valid / out_stall hit, parallel, point_r, point_z
//
// One word per cycle is accepted and delivered when neither side stalls.
// The path runs through four front stages, the queue, two numerator
// stages, one stage per quotient bit of the 33-stage divider, and the output.
// Reset clears only valid bits and the queue pointers and count.
// An output stall with out_valid high freezes the back half; the front keeps going until the
// four-word queue fills, and only then stalls the input.
`default_nettype none
module segment_pair_intersection (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [spi_pkg::CW-1:0] first_start_r,
	input  wire logic signed [spi_pkg::CW-1:0] first_start_z,
	input  wire logic signed [spi_pkg::CW-1:0] first_end_r,
	input  wire logic signed [spi_pkg::CW-1:0] first_end_z,
	input  wire logic signed [spi_pkg::CW-1:0] second_start_r,
	input  wire logic signed [spi_pkg::CW-1:0] second_start_z,
	input  wire logic signed [spi_pkg::CW-1:0] second_end_r,
	input  wire logic signed [spi_pkg::CW-1:0] second_end_z,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               hit,
	output logic                               parallel,
	output logic signed [spi_pkg::CW-1:0]      point_r,
	output logic signed [spi_pkg::CW-1:0]      point_z
);
	logic front_adv, push, pop, not_empty, full;
	spi_pkg::item_t push_item, head;

	assign front_adv = !full;
	assign in_stall  = !front_adv;

	spi_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (front_adv),
		.in_valid       (in_valid),
		.first_start_r  (first_start_r),
		.first_start_z  (first_start_z),
		.first_end_r    (first_end_r),
		.first_end_z    (first_end_z),
		.second_start_r (second_start_r),
		.second_start_z (second_start_z),
		.second_end_r   (second_end_r),
		.second_end_z   (second_end_z),
		.push           (push),
		.push_item      (push_item)
	);

	spi_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.full      (full)
	);

	spi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.hit       (hit),
		.parallel  (parallel),
		.point_r   (point_r),
		.point_z   (point_z)
	);

endmodule
`default_nettype wire
